/* sv/lzfd_pkg.sv */
// Shared types and constants for the flagged-byte LZ decompressor.
package lzfd_pkg;

  // Longest copy run and the width of a run count (1..8).
  localparam int MAX_COPY_LENGTH = 8;
  localparam int CNT_W           = 4;
  // Copy distances run from 1 to 4096.
  localparam int DIST_W          = 13;
  // Length of the copy given by a one-byte token.
  localparam logic [CNT_W-1:0] SHORT_COPY_LEN = 4'd2;
  // Depth of the command queue between parser and executor.
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = 2;

  // One command from the parser: a literal, or a copy run already cut
  // to the declared output size.
  typedef struct packed {
    logic              restart;   // first command of a new stream
    logic              lit;       // literal byte, no history read
    logic [7:0]        lit_byte;
    logic [CNT_W-1:0]  count;     // bytes to emit, 1..8
    logic [DIST_W-1:0] copy_dist; // copy distance, 1..4096
    logic              ends;      // last byte reaches the declared size
  } cmd_t;

endpackage

/* sv/lzfd_front.sv */
// Parser: takes compressed beats and turns them into emit commands.
module lzfd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          start_of_stream,
  input  logic [7:0]    in_byte,
  output logic          cmd_push,
  output lzfd_pkg::cmd_t cmd,
  input  logic          cmd_space
);
  import lzfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_FLAG,
    PH_TOKEN,
    PH_TOKEN2,
    PH_DONE
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  hidx, hidx_next;
  logic [31:0] target, target_next;
  logic [31:0] prod, prod_next;
  logic [8:0]  flags, flags_next;
  logic [6:0]  high, high_next;
  logic        restart_pend;

  phase_t      eff_phase;
  logic [1:0]  eff_hidx;
  logic [31:0] eff_target;
  logic [31:0] eff_prod;
  logic [31:0] rem;
  logic [CNT_W-1:0] len_sel;
  logic [DIST_W-1:0] dist_sel;
  logic        hits;
  logic        is_lit;
  logic        emit_run;
  logic        accept;

  assign in_ready = cmd_space;
  assign accept   = in_valid && in_ready;

  // A start marker clears the parser before this beat is decoded.
  always_comb begin
    eff_phase  = start_of_stream ? PH_HEADER : phase;
    eff_hidx   = start_of_stream ? 2'd0 : hidx;
    eff_target = start_of_stream ? 32'd0 : target;
    eff_prod   = start_of_stream ? 32'd0 : prod;
  end

  // Bytes left to the declared size, and whether this run reaches it.
  assign rem  = eff_target - eff_prod;
  assign hits = 32'(len_sel) >= rem;

  // Decode the beat by parse phase.
  always_comb begin
    phase_next  = eff_phase;
    hidx_next   = eff_hidx;
    target_next = eff_target;
    prod_next   = eff_prod;
    flags_next  = flags;
    high_next   = high;
    len_sel     = CNT_W'(1);
    dist_sel    = DIST_W'(1);
    is_lit      = 1'b0;
    emit_run    = 1'b0;
    case (eff_phase)
      PH_HEADER: begin
        target_next[{eff_hidx, 3'b000} +: 8] = in_byte;
        hidx_next = eff_hidx + 2'd1;
        if (eff_hidx == 2'd3) begin
          phase_next = (target_next == 32'd0) ? PH_DONE : PH_FLAG;
        end
      end
      PH_FLAG: begin
        flags_next = {in_byte, 1'b1};
        phase_next = PH_TOKEN;
      end
      PH_TOKEN: begin
        if (!flags[8]) begin
          is_lit   = 1'b1;
          emit_run = 1'b1;
        end else if (in_byte[7]) begin
          high_next  = in_byte[6:0];
          phase_next = PH_TOKEN2;
        end else begin
          len_sel  = SHORT_COPY_LEN;
          dist_sel = DIST_W'(in_byte[6:0]) + DIST_W'(1);
          emit_run = 1'b1;
        end
      end
      PH_TOKEN2: begin
        len_sel  = CNT_W'(high[6:4]) + CNT_W'(1);
        dist_sel = DIST_W'({high[3:0], in_byte}) + DIST_W'(1);
        emit_run = 1'b1;
      end
      default: begin
      end
    endcase

    // Finished token: advance the flag bits and pick the next phase.
    if (emit_run) begin
      prod_next  = eff_prod + (hits ? 32'(rem[CNT_W-1:0]) : 32'(len_sel));
      flags_next = {flags[7:0], 1'b0};
      if (hits) begin
        phase_next = PH_DONE;
      end else if (flags_next[7:0] == 8'd0) begin
        phase_next = PH_FLAG;
      end else begin
        phase_next = PH_TOKEN;
      end
    end
  end

  // Command toward the executor.
  always_comb begin
    cmd_push      = accept && emit_run;
    cmd.restart   = restart_pend || start_of_stream;
    cmd.lit       = is_lit;
    cmd.lit_byte  = in_byte;
    cmd.count     = hits ? rem[CNT_W-1:0] : len_sel;
    cmd.copy_dist = dist_sel;
    cmd.ends      = hits;
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      hidx         <= 2'd0;
      target       <= 32'd0;
      prod         <= 32'd0;
      flags        <= 9'd0;
      high         <= 7'd0;
      restart_pend <= 1'b1;
    end else if (accept) begin
      phase  <= phase_next;
      hidx   <= hidx_next;
      target <= target_next;
      prod   <= prod_next;
      flags  <= flags_next;
      high   <= high_next;
      if (start_of_stream) begin
        restart_pend <= 1'b1;
      end else if (emit_run) begin
        restart_pend <= 1'b0;
      end
    end
  end

endmodule

/* sv/lzfd_queue.sv */
// Small command queue between the parser and the executor.
module lzfd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lzfd_pkg::cmd_t push_cmd,
  output logic           space,
  input  logic           pop,
  output logic           head_valid,
  output lzfd_pkg::cmd_t head_cmd
);
  import lzfd_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign space      = fill != (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = fill != '0;
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && space;
  assign do_pop     = pop && head_valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

/* sv/lzfd_back.sv */
// Executor: emits command bytes via history, one per cycle unless stalled.
module lzfd_back #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lzfd_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           run_last,
  output logic           stream_last,
  output logic           before_start
);
  import lzfd_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0]   DEPTH_C = (AW+1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_W  = AW'(HISTORY_DEPTH - 1);

  logic [7:0] hist [HISTORY_DEPTH];

  // Issue stage: the command being walked byte by byte.
  logic              iss_active;
  logic              iss_lit;
  logic [7:0]        iss_byte;
  logic [DIST_W-1:0] iss_dist;
  logic [CNT_W-1:0]  iss_left;
  logic              iss_end;
  logic [31:0]       iss_pos;
  logic [AW-1:0]     iss_wpos;

  // Read stage: one byte waiting on its history read.
  logic              rd_valid;
  logic              rd_lit;
  logic [7:0]        rd_lbyte;
  logic              rd_before;
  logic              rd_fwd;
  logic [7:0]        rd_fwd_byte;
  logic [7:0]        rd_mem;
  logic              rd_last;
  logic              rd_slast;
  logic [AW-1:0]     rd_wpos;
  logic [7:0]        rd_byte;

  logic              rd_move;
  logic              iss_fire;
  logic              iss_load;
  logic              cur_before;
  logic              cur_fwd;
  logic [AW:0]       wext;
  logic [AW:0]       dext;
  logic [AW-1:0]     src_addr;
  logic [31:0]       pos_adv;
  logic [AW-1:0]     wpos_adv;

  // Stage handshakes.
  assign rd_move  = rd_valid && (!out_valid || out_ready);
  assign iss_fire = iss_active && (!rd_valid || rd_move);
  assign iss_load = q_valid && (!iss_active || (iss_fire && iss_left == CNT_W'(1)));
  assign q_pop    = iss_load;

  // Source address in the ring, wrapped below zero.
  always_comb begin
    wext = {1'b0, iss_wpos};
    dext = (AW+1)'(iss_dist);
    if (wext >= dext) begin
      src_addr = AW'(wext - dext);
    end else begin
      src_addr = AW'(wext + DEPTH_C - dext);
    end
  end

  // A distance past the stream start reads as zero. Distance one reads the
  // byte written in this same cycle, so it comes from the read stage.
  assign cur_before = !iss_lit && (iss_pos < 32'(iss_dist));
  assign cur_fwd    = !iss_lit && !cur_before && (iss_dist == DIST_W'(1)) && rd_move;

  assign rd_byte = rd_lit ? rd_lbyte :
                   rd_before ? 8'd0 :
                   rd_fwd ? rd_fwd_byte : rd_mem;

  assign pos_adv  = iss_fire ? iss_pos + 32'd1 : iss_pos;
  assign wpos_adv = !iss_fire ? iss_wpos :
                    (iss_wpos == LAST_W) ? '0 : iss_wpos + AW'(1);

  // History memory: read at issue, written when a byte leaves the read stage.
  always_ff @(posedge clk) begin
    if (iss_fire) begin
      rd_mem <= hist[src_addr];
    end
    if (rd_move) begin
      hist[rd_wpos] <= rd_byte;
    end
  end

  // Issue stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_active <= 1'b0;
      iss_pos    <= 32'd0;
      iss_wpos   <= '0;
      iss_left   <= '0;
    end else begin
      iss_pos  <= pos_adv;
      iss_wpos <= wpos_adv;
      if (iss_fire) begin
        iss_left <= iss_left - CNT_W'(1);
        if (iss_left == CNT_W'(1)) begin
          iss_active <= 1'b0;
        end
      end
      if (iss_load) begin
        iss_active <= 1'b1;
        iss_left   <= q_cmd.count;
        if (q_cmd.restart) begin
          iss_pos  <= 32'd0;
          iss_wpos <= '0;
        end
      end
    end
  end

  // Command payload for the issue stage.
  always_ff @(posedge clk) begin
    if (iss_load) begin
      iss_lit  <= q_cmd.lit;
      iss_byte <= q_cmd.lit_byte;
      iss_dist <= q_cmd.copy_dist;
      iss_end  <= q_cmd.ends;
    end
  end

  // Read stage and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (iss_fire) begin
        rd_valid <= 1'b1;
      end else if (rd_move) begin
        rd_valid <= 1'b0;
      end
      if (rd_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (iss_fire) begin
      rd_lit      <= iss_lit;
      rd_lbyte    <= iss_byte;
      rd_before   <= cur_before;
      rd_fwd      <= cur_fwd;
      rd_fwd_byte <= rd_byte;
      rd_last     <= iss_left == CNT_W'(1);
      rd_slast    <= (iss_left == CNT_W'(1)) && iss_end;
      rd_wpos     <= iss_wpos;
    end
    if (rd_move) begin
      out_byte     <= rd_byte;
      run_last     <= rd_last;
      stream_last  <= rd_slast;
      before_start <= rd_before && !rd_lit;
    end
  end

endmodule

/* sv/lz_flagged_byte_decompressor_top.sv */
// Top level of the flagged-byte LZ decompressor.
// Compressed bytes enter one beat per cycle while in_ready is high: four size bytes (least
// significant first), then flag bytes each governing eight literal or copy tokens. A parser
// decodes the beats into emit commands held in a four-entry queue, and an executor walks each
// command at one output beat per cycle, while out_ready allows, through a HISTORY_DEPTH-byte
// history memory; a literal emits one byte, a short copy up to two and a long copy up to eight;
// flag bytes and header bytes produce no output. Copies are cut at the declared size, later
// beats are ignored until start_of_stream, and a copy reaching before the stream start outputs
// zero with before_start set. The history needs no clearing after reset. HISTORY_DEPTH may be
// any value from 4096 to 65536.
module lz_flagged_byte_decompressor_top #(
  parameter int HISTORY_DEPTH = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       start_of_stream,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       stream_last,
  output logic       before_start
);
  import lzfd_pkg::*;

  logic cmd_push;
  cmd_t cmd;
  logic cmd_space;
  logic q_pop;
  logic q_valid;
  cmd_t q_cmd;

  // Parser.
  lzfd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .start_of_stream (start_of_stream),
    .in_byte         (in_byte),
    .cmd_push        (cmd_push),
    .cmd             (cmd),
    .cmd_space       (cmd_space)
  );

  // Command queue.
  lzfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .space      (cmd_space),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  // Executor with history memory.
  lzfd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .stream_last  (stream_last),
    .before_start (before_start)
  );

endmodule

/* sv/lzfd_checker.sv */
// Port-level checks for the decompressor, bound to the top level.
module lzfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_last,
  input logic       before_start
);

  // A stalled output beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("output beat changed while stalled");

  // A byte taken from before the stream start is zero.
  a_before_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && before_start |-> out_byte == 8'd0)
    else $error("before_start beat carries a nonzero byte");

  // The byte that reaches the declared size ends its input's run.
  a_stream_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && stream_last |-> run_last)
    else $error("stream_last without run_last");

  // Reset leaves no output beat pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind lz_flagged_byte_decompressor_top lzfd_checker u_lzfd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .run_last     (run_last),
  .stream_last  (stream_last),
  .before_start (before_start)
);
